// ----- design/sdsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsh_pkg
// Shared constants for the SD card SPI host engine.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int WAKE_BYTES  = 10;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_WAKE   = 4'd1;
    localparam logic [3:0] PH_DESEL  = 4'd2;
    localparam logic [3:0] PH_FRAME  = 4'd3;
    localparam logic [3:0] PH_STUFF  = 4'd4;
    localparam logic [3:0] PH_RESP   = 4'd5;
    localparam logic [3:0] PH_TRAIL  = 4'd6;
    localparam logic [3:0] PH_TOKEN  = 4'd7;
    localparam logic [3:0] PH_RDATA  = 4'd8;
    localparam logic [3:0] PH_RCRC   = 4'd9;
    localparam logic [3:0] PH_READY  = 4'd10;
    localparam logic [3:0] PH_WTOKEN = 4'd11;
    localparam logic [3:0] PH_WDATA  = 4'd12;
    localparam logic [3:0] PH_WCRC   = 4'd13;
    localparam logic [3:0] PH_WRESP  = 4'd14;
    localparam logic [3:0] PH_END    = 4'd15;

    localparam logic [3:0] SG_CMD0    = 4'd0;
    localparam logic [3:0] SG_CMD8    = 4'd1;
    localparam logic [3:0] SG_PROBE55 = 4'd2;
    localparam logic [3:0] SG_PROBE41 = 4'd3;
    localparam logic [3:0] SG_V1_55   = 4'd4;
    localparam logic [3:0] SG_V1_41   = 4'd5;
    localparam logic [3:0] SG_MMC1    = 4'd6;
    localparam logic [3:0] SG_V2_55   = 4'd7;
    localparam logic [3:0] SG_V2_41   = 4'd8;
    localparam logic [3:0] SG_CMD58   = 4'd9;
    localparam logic [3:0] SG_CMD16   = 4'd10;
    localparam logic [3:0] SG_RDCMD   = 4'd11;
    localparam logic [3:0] SG_RDSTOP  = 4'd12;
    localparam logic [3:0] SG_WRCMD   = 4'd13;

    localparam logic [1:0] RQ_NONE  = 2'd0;
    localparam logic [1:0] RQ_INIT  = 2'd1;
    localparam logic [1:0] RQ_READ  = 2'd2;
    localparam logic [1:0] RQ_WRITE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BADRESP = 2'd2;
    localparam logic [1:0] ST_NOCARD  = 2'd3;

    localparam logic [2:0] CT_NONE  = 3'd0;
    localparam logic [2:0] CT_V1    = 3'd1;
    localparam logic [2:0] CT_V2    = 3'd2;
    localparam logic [2:0] CT_V2HC  = 3'd3;
    localparam logic [2:0] CT_MMC   = 3'd4;
    localparam logic [2:0] CT_ERROR = 3'd5;

    localparam logic [2:0] RG_READY = 3'd0;
    localparam logic [2:0] RG_TOKEN = 3'd1;
    localparam logic [2:0] RG_RESP  = 3'd2;
    localparam logic [2:0] RG_IDLE  = 3'd3;
    localparam logic [2:0] RG_POLL  = 3'd4;

    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] TOK_START  = 8'hFE;
    localparam logic [7:0] TOK_MULTI  = 8'hFC;
    localparam logic [7:0] TOK_STOP   = 8'hFD;

    // result item fields, packed into m_axis_tdata at the top level
    typedef struct packed {
        logic [2:0] card_type;
        logic [1:0] status;
        logic       done_res;
        logic       data_request;
        logic       read_valid;
        logic [7:0] read_data;
        logic       slow_clock;
        logic       chip_select;
        logic       send_valid;
        logic [7:0] tx_byte;
    } result_t;

endpackage

// ----- design/sd_card_spi_host_engine.sv -----
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine
// Host side sequencer for SD cards in SPI mode: init, sector read and write.
// ----------------------------------------------------------------------------
// Usage: the input stream carries either a host request (command 1 init,
// 2 read, 3 write) or, with command 0, the byte received in the SPI
// transfer just finished. Each input transfer yields exactly one result
// transfer: the next byte to send, chip select, slow clock, sector data
// read, a data request and completion status. After a result with
// data_request set, the next input carries the host byte in write_byte.
// The result is registered, valid in the cycle after the input transfer;
// an item can enter every cycle while results are taken, as the state
// update is one combinational pass from input to the result register.
// The result register frees itself when taken; if the receiver stalls,
// s_axis_tready drops until the held result is taken.
// Reset (aresetn low, synchronous) puts the sequencer in idle, clears the
// counters and restores the timeout registers to their defaults.
// Timeout registers sit on the APB port at byte addresses 0,4,8,12,16.
// ----------------------------------------------------------------------------
module sd_card_spi_host_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], rx_byte[9:2], start_sector[41:10], sector_count[49:42],
    // write_byte[57:50]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], send_valid[8], chip_select[9], slow_clock[10],
    // read_data[18:11], read_valid[19], data_request[20], done_res[21],
    // status[23:22], card_type[26:24]
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0] ready_lim_reg;
    logic [11:0] token_lim_reg;
    logic [7:0]  resp_lim_reg;
    logic [7:0]  idle_lim_reg;
    logic [15:0] poll_lim_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [23:0] wcnt_reg, wcnt_next;
    logic [15:0] rcnt_reg, rcnt_next;
    logic [2:0]  kind_reg, kind_next;
    logic [47:0] frame_reg, frame_next;
    logic [31:0] reply_reg, reply_next;
    logic [7:0]  left_reg, left_next;
    logic [3:0]  stage_reg, stage_next;
    logic [1:0]  req_reg, req_next;
    logic        cmd12_reg, cmd12_next;
    logic [1:0]  fst_reg, fst_next;
    logic        multi_reg, multi_next;
    logic        stop_reg, stop_next;

    logic              out_valid_reg;
    sdsh_pkg::result_t out_reg;
    sdsh_pkg::result_t res;

    logic        take;
    logic [1:0]  in_cmd;
    logic [7:0]  rx;
    logic [31:0] in_sector;
    logic [7:0]  in_count;
    logic [7:0]  wb;
    logic [2:0]  reg_index;

    assign in_cmd    = s_axis_tdata[1:0];
    assign rx        = s_axis_tdata[9:2];
    assign in_sector = s_axis_tdata[41:10];
    assign in_count  = s_axis_tdata[49:42];
    assign wb        = s_axis_tdata[57:50];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg};
    assign pready        = 1'b1;
    assign reg_index     = paddr[4:2];

    always_comb begin
        case (reg_index)
            sdsh_pkg::RG_READY: prdata = {8'd0, ready_lim_reg};
            sdsh_pkg::RG_TOKEN: prdata = {20'd0, token_lim_reg};
            sdsh_pkg::RG_RESP:  prdata = {24'd0, resp_lim_reg};
            sdsh_pkg::RG_IDLE:  prdata = {24'd0, idle_lim_reg};
            sdsh_pkg::RG_POLL:  prdata = {16'd0, poll_lim_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_lim_reg <= 24'hFFFFFF;
            token_lim_reg <= 12'hFFF;
            resp_lim_reg  <= 8'h1F;
            idle_lim_reg  <= 8'd20;
            poll_lim_reg  <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            case (reg_index)
                sdsh_pkg::RG_READY: ready_lim_reg <= pwdata[23:0];
                sdsh_pkg::RG_TOKEN: token_lim_reg <= pwdata[11:0];
                sdsh_pkg::RG_RESP:  resp_lim_reg  <= pwdata[7:0];
                sdsh_pkg::RG_IDLE:  idle_lim_reg  <= pwdata[7:0];
                sdsh_pkg::RG_POLL:  poll_lim_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // one step of the sequencer
    always_comb begin
        logic [7:0]  tx;
        logic        snd, cs;
        logic [15:0] rinc;
        logic [23:0] winc;
        logic [1:0]  r1st;
        logic [1:0]  bres;
        logic        do_send, do_fin, do_blkr, do_blkw;
        logic [5:0]  s_cmd;
        logic [31:0] s_arg;
        logic [3:0]  s_stg;
        logic [1:0]  f_st;
        logic [7:0]  crc;

        phase_next = phase_reg; bcnt_next = bcnt_reg; wcnt_next = wcnt_reg;
        rcnt_next = rcnt_reg; kind_next = kind_reg; frame_next = frame_reg;
        reply_next = reply_reg; left_next = left_reg; stage_next = stage_reg;
        req_next = req_reg; cmd12_next = cmd12_reg; fst_next = fst_reg;
        multi_next = multi_reg; stop_next = stop_reg;
        tx = 8'd0; snd = 1'b0; cs = 1'b0;
        res = '0;
        do_send = 1'b0; do_fin = 1'b0; do_blkr = 1'b0; do_blkw = 1'b0;
        s_cmd = 6'd0; s_arg = 32'd0; s_stg = sdsh_pkg::SG_CMD0;
        f_st = sdsh_pkg::ST_OK; bres = sdsh_pkg::ST_OK;
        rinc = rcnt_reg + 16'd1;
        winc = wcnt_reg + 24'd1;
        r1st = rx[7] ? sdsh_pkg::ST_TIMEOUT : sdsh_pkg::ST_BADRESP;
        crc = 8'h01;

        if (in_cmd != sdsh_pkg::RQ_NONE) begin
            req_next = in_cmd; rcnt_next = 16'd0; wcnt_next = 24'd0;
            bcnt_next = 10'd0; fst_next = sdsh_pkg::ST_OK; stop_next = 1'b0;
            if (in_cmd == sdsh_pkg::RQ_INIT) begin
                kind_next = sdsh_pkg::CT_NONE; phase_next = sdsh_pkg::PH_WAKE;
                bcnt_next = 10'd1; tx = sdsh_pkg::BYTE_FF; snd = 1'b1;
            end else begin
                left_next = in_count;
                multi_next = (in_count != 8'd1);
                s_arg = (kind_reg == sdsh_pkg::CT_V2HC) ? in_sector
                                                         : {in_sector[22:0], 9'd0};
                do_send = 1'b1;
                if (in_cmd == sdsh_pkg::RQ_READ) begin
                    s_cmd = (in_count != 8'd1) ? 6'd18 : 6'd17;
                    s_stg = sdsh_pkg::SG_RDCMD;
                end else begin
                    s_cmd = (in_count != 8'd1) ? 6'd25 : 6'd24;
                    s_stg = sdsh_pkg::SG_WRCMD;
                end
            end
        end else begin
            case (phase_reg)
                sdsh_pkg::PH_IDLE: ;
                sdsh_pkg::PH_WAKE: begin
                    if (bcnt_reg < 10'(sdsh_pkg::WAKE_BYTES)) begin
                        bcnt_next = bcnt_reg + 10'd1; tx = sdsh_pkg::BYTE_FF; snd = 1'b1;
                    end else begin
                        do_send = 1'b1; s_cmd = 6'd0; s_stg = sdsh_pkg::SG_CMD0;
                    end
                end
                sdsh_pkg::PH_DESEL: begin
                    bcnt_next = 10'd1; phase_next = sdsh_pkg::PH_FRAME;
                    tx = frame_reg[47:40]; snd = 1'b1; cs = 1'b1;
                end
                sdsh_pkg::PH_FRAME: begin
                    snd = 1'b1; cs = 1'b1;
                    if (bcnt_reg < 10'd6) begin
                        case (bcnt_reg[2:0])
                            3'd1:    tx = frame_reg[39:32];
                            3'd2:    tx = frame_reg[31:24];
                            3'd3:    tx = frame_reg[23:16];
                            3'd4:    tx = frame_reg[15:8];
                            default: tx = frame_reg[7:0];
                        endcase
                        bcnt_next = bcnt_reg + 10'd1;
                    end else begin
                        phase_next = cmd12_reg ? sdsh_pkg::PH_STUFF : sdsh_pkg::PH_RESP;
                        wcnt_next = 24'd0; tx = sdsh_pkg::BYTE_FF;
                    end
                end
                sdsh_pkg::PH_STUFF: begin
                    phase_next = sdsh_pkg::PH_RESP; wcnt_next = 24'd0;
                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                end
                sdsh_pkg::PH_RESP: begin
                    if (rx[7] && wcnt_reg < {16'd0, resp_lim_reg}) begin
                        wcnt_next = winc; tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                    end else begin
                        case (stage_reg)
                            sdsh_pkg::SG_CMD0: begin
                                if (rx == 8'd1) begin
                                    do_send = 1'b1; s_cmd = 6'd8; s_arg = 32'h1AA;
                                    s_stg = sdsh_pkg::SG_CMD8;
                                end else begin
                                    rcnt_next = rinc;
                                    if (rinc <= {8'd0, idle_lim_reg}) begin
                                        do_send = 1'b1; s_cmd = 6'd0;
                                        s_stg = sdsh_pkg::SG_CMD0;
                                    end else begin
                                        do_fin = 1'b1; f_st = sdsh_pkg::ST_NOCARD;
                                    end
                                end
                            end
                            sdsh_pkg::SG_CMD8: begin
                                if (rx == 8'd1) begin
                                    phase_next = sdsh_pkg::PH_TRAIL; bcnt_next = 10'd0;
                                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                                end else begin
                                    do_send = 1'b1; s_cmd = 6'd55;
                                    s_stg = sdsh_pkg::SG_PROBE55;
                                end
                            end
                            sdsh_pkg::SG_PROBE55: begin
                                do_send = 1'b1; s_cmd = 6'd41; s_stg = sdsh_pkg::SG_PROBE41;
                            end
                            sdsh_pkg::SG_PROBE41: begin
                                rcnt_next = 16'd0; do_send = 1'b1;
                                if (rx <= 8'd1) begin
                                    kind_next = sdsh_pkg::CT_V1; s_cmd = 6'd55;
                                    s_stg = sdsh_pkg::SG_V1_55;
                                end else begin
                                    kind_next = sdsh_pkg::CT_MMC; s_cmd = 6'd1;
                                    s_stg = sdsh_pkg::SG_MMC1;
                                end
                            end
                            sdsh_pkg::SG_V1_55: begin
                                do_send = 1'b1; s_cmd = 6'd41; s_stg = sdsh_pkg::SG_V1_41;
                            end
                            sdsh_pkg::SG_V2_55: begin
                                do_send = 1'b1; s_cmd = 6'd41; s_arg = 32'h40000000;
                                s_stg = sdsh_pkg::SG_V2_41;
                            end
                            sdsh_pkg::SG_V1_41, sdsh_pkg::SG_MMC1, sdsh_pkg::SG_V2_41: begin
                                if (rx == 8'd0) begin
                                    do_send = 1'b1;
                                    if (stage_reg == sdsh_pkg::SG_V2_41) begin
                                        s_cmd = 6'd58; s_stg = sdsh_pkg::SG_CMD58;
                                    end else begin
                                        s_cmd = 6'd16; s_arg = 32'(sdsh_pkg::BLOCK_BYTES);
                                        s_stg = sdsh_pkg::SG_CMD16;
                                    end
                                end else begin
                                    rcnt_next = rinc;
                                    if (rinc < poll_lim_reg) begin
                                        do_send = 1'b1;
                                        case (stage_reg)
                                            sdsh_pkg::SG_V1_41: begin
                                                s_cmd = 6'd55; s_stg = sdsh_pkg::SG_V1_55;
                                            end
                                            sdsh_pkg::SG_MMC1: begin
                                                s_cmd = 6'd1; s_stg = sdsh_pkg::SG_MMC1;
                                            end
                                            default: begin
                                                s_cmd = 6'd55; s_stg = sdsh_pkg::SG_V2_55;
                                            end
                                        endcase
                                    end else begin
                                        kind_next = sdsh_pkg::CT_ERROR;
                                        do_fin = 1'b1; f_st = sdsh_pkg::ST_TIMEOUT;
                                    end
                                end
                            end
                            sdsh_pkg::SG_CMD58: begin
                                if (rx == 8'd0) begin
                                    phase_next = sdsh_pkg::PH_TRAIL; bcnt_next = 10'd0;
                                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                                end else begin
                                    kind_next = sdsh_pkg::CT_ERROR; do_fin = 1'b1; f_st = r1st;
                                end
                            end
                            sdsh_pkg::SG_CMD16: begin
                                do_fin = 1'b1;
                                if (rx == 8'd0) f_st = sdsh_pkg::ST_OK;
                                else begin
                                    kind_next = sdsh_pkg::CT_ERROR; f_st = r1st;
                                end
                            end
                            sdsh_pkg::SG_RDCMD: begin
                                if (rx == 8'd0) begin
                                    phase_next = sdsh_pkg::PH_TOKEN; wcnt_next = 24'd0;
                                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                                end else begin
                                    do_fin = 1'b1; f_st = r1st;
                                end
                            end
                            sdsh_pkg::SG_RDSTOP: begin
                                do_fin = 1'b1; f_st = fst_reg;
                            end
                            sdsh_pkg::SG_WRCMD: begin
                                if (rx == 8'd0) begin
                                    phase_next = sdsh_pkg::PH_READY; wcnt_next = 24'd0;
                                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                                end else begin
                                    do_fin = 1'b1; f_st = r1st;
                                end
                            end
                            default: begin
                                do_fin = 1'b1; f_st = sdsh_pkg::ST_BADRESP;
                            end
                        endcase
                    end
                end
                sdsh_pkg::PH_TRAIL: begin
                    reply_next = {reply_reg[23:0], rx};
                    bcnt_next = bcnt_reg + 10'd1;
                    if (bcnt_reg + 10'd1 < 10'd4) begin
                        tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                    end else if (stage_reg == sdsh_pkg::SG_CMD8) begin
                        // reply_next[15:0] is the echoed voltage and check pattern
                        if (reply_next[15:8] == 8'h01 && reply_next[7:0] == 8'hAA) begin
                            rcnt_next = 16'd0; do_send = 1'b1; s_cmd = 6'd55;
                            s_stg = sdsh_pkg::SG_V2_55;
                        end else begin
                            do_fin = 1'b1; f_st = sdsh_pkg::ST_NOCARD;
                        end
                    end else begin
                        kind_next = reply_next[30] ? sdsh_pkg::CT_V2HC : sdsh_pkg::CT_V2;
                        do_send = 1'b1; s_cmd = 6'd16; s_arg = 32'(sdsh_pkg::BLOCK_BYTES);
                        s_stg = sdsh_pkg::SG_CMD16;
                    end
                end
                sdsh_pkg::PH_TOKEN: begin
                    if (rx == sdsh_pkg::TOK_START) begin
                        phase_next = sdsh_pkg::PH_RDATA; bcnt_next = 10'd0;
                        tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                    end else begin
                        wcnt_next = winc;
                        if (winc < {12'd0, token_lim_reg}) begin
                            tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                        end else begin
                            do_blkr = 1'b1; bres = sdsh_pkg::ST_TIMEOUT;
                        end
                    end
                end
                sdsh_pkg::PH_RDATA: begin
                    res.read_data = rx; res.read_valid = 1'b1;
                    bcnt_next = bcnt_reg + 10'd1;
                    if (bcnt_reg == 10'(sdsh_pkg::BLOCK_BYTES - 1)) begin
                        phase_next = sdsh_pkg::PH_RCRC; bcnt_next = 10'd0;
                    end
                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                end
                sdsh_pkg::PH_RCRC: begin
                    if (bcnt_reg == 10'd0) begin
                        bcnt_next = 10'd1; tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                    end else begin
                        do_blkr = 1'b1; bres = sdsh_pkg::ST_OK;
                    end
                end
                sdsh_pkg::PH_READY: begin
                    if (rx == sdsh_pkg::BYTE_FF) begin
                        phase_next = sdsh_pkg::PH_WTOKEN; snd = 1'b1; cs = 1'b1;
                        tx = stop_reg ? sdsh_pkg::TOK_STOP
                           : (multi_reg ? sdsh_pkg::TOK_MULTI : sdsh_pkg::TOK_START);
                        res.data_request = !stop_reg;
                    end else begin
                        wcnt_next = winc;
                        if (winc < ready_lim_reg) begin
                            tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                        end else begin
                            do_blkw = 1'b1; bres = sdsh_pkg::ST_TIMEOUT;
                        end
                    end
                end
                sdsh_pkg::PH_WTOKEN: begin
                    if (stop_reg) begin
                        do_fin = 1'b1; f_st = fst_reg;
                    end else begin
                        phase_next = sdsh_pkg::PH_WDATA; bcnt_next = 10'd1;
                        tx = wb; snd = 1'b1; cs = 1'b1; res.data_request = 1'b1;
                    end
                end
                sdsh_pkg::PH_WDATA: begin
                    snd = 1'b1; cs = 1'b1;
                    if (bcnt_reg != 10'(sdsh_pkg::BLOCK_BYTES)) begin
                        tx = wb; bcnt_next = bcnt_reg + 10'd1;
                        res.data_request = (bcnt_reg != 10'(sdsh_pkg::BLOCK_BYTES - 1));
                    end else begin
                        phase_next = sdsh_pkg::PH_WCRC; bcnt_next = 10'd0;
                        tx = sdsh_pkg::BYTE_FF;
                    end
                end
                sdsh_pkg::PH_WCRC: begin
                    if (bcnt_reg == 10'd0) bcnt_next = 10'd1;
                    else phase_next = sdsh_pkg::PH_WRESP;
                    tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
                end
                sdsh_pkg::PH_WRESP: begin
                    do_blkw = 1'b1;
                    bres = (rx[4:0] == 5'h05) ? sdsh_pkg::ST_OK : sdsh_pkg::ST_BADRESP;
                end
                sdsh_pkg::PH_END: begin
                    res.done_res = 1'b1; res.status = fst_reg;
                    phase_next = sdsh_pkg::PH_IDLE; req_next = sdsh_pkg::RQ_NONE;
                end
                default: phase_next = sdsh_pkg::PH_IDLE;
            endcase
        end

        // end of a read block
        if (do_blkr) begin
            if (bres != sdsh_pkg::ST_OK && fst_reg == sdsh_pkg::ST_OK) fst_next = bres;
            if (!multi_reg) begin
                do_fin = 1'b1;
                f_st = (bres != sdsh_pkg::ST_OK && fst_reg == sdsh_pkg::ST_OK) ? bres
                                                                                : fst_reg;
            end else if (bres == sdsh_pkg::ST_OK && left_reg != 8'd1) begin
                left_next = left_reg - 8'd1; phase_next = sdsh_pkg::PH_TOKEN;
                wcnt_next = 24'd0; tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
            end else begin
                if (bres == sdsh_pkg::ST_OK) left_next = left_reg - 8'd1;
                do_send = 1'b1; s_cmd = 6'd12; s_stg = sdsh_pkg::SG_RDSTOP;
            end
        end

        // end of a written block
        if (do_blkw) begin
            if (bres != sdsh_pkg::ST_OK && fst_reg == sdsh_pkg::ST_OK) fst_next = bres;
            if (!multi_reg || stop_reg) begin
                do_fin = 1'b1;
                f_st = (bres != sdsh_pkg::ST_OK && fst_reg == sdsh_pkg::ST_OK) ? bres
                                                                                : fst_reg;
            end else begin
                if (bres == sdsh_pkg::ST_OK) left_next = left_reg - 8'd1;
                if (!(bres == sdsh_pkg::ST_OK && left_reg != 8'd1)) stop_next = 1'b1;
                phase_next = sdsh_pkg::PH_READY; wcnt_next = 24'd0;
                tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b1;
            end
        end

        if (do_send) begin
            if (s_cmd == 6'd0) crc = 8'h95;
            if (s_cmd == 6'd8) crc = 8'h87;
            cmd12_next = (s_cmd == 6'd12);
            stage_next = s_stg;
            frame_next = {2'b01, s_cmd, s_arg, crc};
            phase_next = sdsh_pkg::PH_DESEL;
            tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b0;
        end

        if (do_fin) begin
            fst_next = f_st; phase_next = sdsh_pkg::PH_END;
            tx = sdsh_pkg::BYTE_FF; snd = 1'b1; cs = 1'b0;
        end

        res.tx_byte     = tx;
        res.send_valid  = snd;
        res.chip_select = cs;
        res.slow_clock  = snd && (req_next == sdsh_pkg::RQ_INIT);
        res.card_type   = kind_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sdsh_pkg::PH_IDLE;
            bcnt_reg <= 10'd0; wcnt_reg <= 24'd0; rcnt_reg <= 16'd0;
            kind_reg <= sdsh_pkg::CT_NONE; frame_reg <= 48'd0; left_reg <= 8'd0;
            stage_reg <= sdsh_pkg::SG_CMD0; req_reg <= sdsh_pkg::RQ_NONE;
            cmd12_reg <= 1'b0; fst_reg <= sdsh_pkg::ST_OK;
            multi_reg <= 1'b0; stop_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next; bcnt_reg <= bcnt_next; wcnt_reg <= wcnt_next;
                rcnt_reg <= rcnt_next; kind_reg <= kind_next; frame_reg <= frame_next;
                left_reg <= left_next; stage_reg <= stage_next; req_reg <= req_next;
                cmd12_reg <= cmd12_next; fst_reg <= fst_next;
                multi_reg <= multi_next; stop_reg <= stop_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            reply_reg <= reply_next;
            out_reg <= res;
        end
    end

endmodule

// ----- test/tb_sdsh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sdsh_pkg
// SD command indexes and card reply codes shared by the bench and checker.
// ----------------------------------------------------------------------------
package tb_sdsh_pkg;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_MMC_INIT  = 6'd1;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
    localparam logic [5:0] CMD_RD_MULTI  = 6'd18;
    localparam logic [5:0] CMD_WR_SINGLE = 6'd24;
    localparam logic [5:0] CMD_WR_MULTI  = 6'd25;
    localparam logic [5:0] CMD_APP_INIT  = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;

    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_ILLEGAL = 8'h05;

    localparam logic [7:0] VHS_VOLT    = 8'h01;
    localparam logic [7:0] VHS_PATTERN = 8'hAA;
    localparam logic [31:0] VHS_ARG    = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG    = 32'h4000_0000;
    localparam logic [4:0] DRESP_OK    = 5'h05;

    localparam logic [7:0] CRC_GO_IDLE = 8'h95;
    localparam logic [7:0] CRC_IF_COND = 8'h87;
    localparam logic [7:0] CRC_DUMMY   = 8'h01;

endpackage

// ----- test/sdsh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsh_checker
// Watches the request, result and register channels of the SD SPI host
// engine, predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module sdsh_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          n_errors,
    output int          n_pending
);

    logic [23:0] lim_ready;
    logic [11:0] lim_token;
    logic [7:0]  lim_resp;
    logic [7:0]  lim_idle;
    logic [15:0] lim_poll;

    logic [3:0]  ph;
    int          bcnt;
    logic [23:0] wcnt;
    logic [15:0] rcnt;
    logic [2:0]  kind;
    logic [47:0] frame;
    logic [31:0] reply;
    logic [7:0]  left;
    logic [3:0]  stg;
    logic [1:0]  req;
    logic [5:0]  ccmd;
    logic [1:0]  fstat;
    logic        multi;
    logic        stopping;

    sdsh_pkg::result_t res;
    sdsh_pkg::result_t due_answers[$];

    task host_reset();
        lim_ready = 24'hFF_FFFF;
        lim_token = 12'hFFF;
        lim_resp  = 8'd31;
        lim_idle  = 8'd20;
        lim_poll  = 16'hFFFF;
        ph = sdsh_pkg::PH_IDLE;
        bcnt = 0; wcnt = '0; rcnt = '0; kind = sdsh_pkg::CT_NONE; frame = '0; reply = '0;
        left = '0; stg = sdsh_pkg::SG_CMD0; req = sdsh_pkg::RQ_NONE; ccmd = '0;
        fstat = sdsh_pkg::ST_OK;
        multi = 1'b0; stopping = 1'b0;
    endtask

    task emit(input logic [7:0] tx, input logic cs);
        res.tx_byte = tx;
        res.send_valid = 1'b1;
        res.chip_select = cs;
    endtask

    task send_cmd(input logic [5:0] cmd, input logic [31:0] arg, input logic [3:0] s);
        logic [7:0] crc;
        crc = tb_sdsh_pkg::CRC_DUMMY;
        if (cmd == tb_sdsh_pkg::CMD_GO_IDLE) crc = tb_sdsh_pkg::CRC_GO_IDLE;
        if (cmd == tb_sdsh_pkg::CMD_IF_COND) crc = tb_sdsh_pkg::CRC_IF_COND;
        ccmd = cmd;
        stg = s;
        frame = {2'b01, cmd, arg, crc};
        ph = sdsh_pkg::PH_DESEL;
        emit(sdsh_pkg::BYTE_FF, 1'b0);
    endtask

    task finish_req(input logic [1:0] st);
        fstat = st;
        ph = sdsh_pkg::PH_END;
        emit(sdsh_pkg::BYTE_FF, 1'b0);
    endtask

    function automatic logic [1:0] r1_fail(input logic [7:0] r1);
        return r1[7] ? sdsh_pkg::ST_TIMEOUT : sdsh_pkg::ST_BADRESP;
    endfunction

    task enter_wait(input logic [3:0] p);
        ph = p;
        wcnt = '0;
        emit(sdsh_pkg::BYTE_FF, 1'b1);
    endtask

    task block_read(input logic [1:0] r);
        if (r != sdsh_pkg::ST_OK && fstat == sdsh_pkg::ST_OK) fstat = r;
        if (!multi) begin
            finish_req(fstat);
            return;
        end
        if (r == sdsh_pkg::ST_OK) begin
            left = left - 8'd1;
            if (left != 0) begin
                enter_wait(sdsh_pkg::PH_TOKEN);
                return;
            end
        end
        send_cmd(tb_sdsh_pkg::CMD_STOP, '0, sdsh_pkg::SG_RDSTOP);
    endtask

    task block_written(input logic [1:0] r);
        if (r != sdsh_pkg::ST_OK && fstat == sdsh_pkg::ST_OK) fstat = r;
        if (!multi || stopping) begin
            finish_req(fstat);
            return;
        end
        if (r == sdsh_pkg::ST_OK) begin
            left = left - 8'd1;
            if (left != 0) begin
                enter_wait(sdsh_pkg::PH_READY);
                return;
            end
        end
        stopping = 1'b1;
        enter_wait(sdsh_pkg::PH_READY);
    endtask

    task poll_again(input logic [5:0] cmd, input logic [3:0] s);
        rcnt = rcnt + 16'd1;
        if (rcnt < lim_poll) begin
            send_cmd(cmd, '0, s);
        end else begin
            kind = sdsh_pkg::CT_ERROR;
            finish_req(sdsh_pkg::ST_TIMEOUT);
        end
    endtask

    task on_r1(input logic [7:0] r1);
        case (stg)
            sdsh_pkg::SG_CMD0: begin
                if (r1 == tb_sdsh_pkg::R1_IDLE) begin
                    send_cmd(tb_sdsh_pkg::CMD_IF_COND, tb_sdsh_pkg::VHS_ARG,
                             sdsh_pkg::SG_CMD8);
                end else begin
                    rcnt = rcnt + 16'd1;
                    if (rcnt <= lim_idle) begin
                        send_cmd(tb_sdsh_pkg::CMD_GO_IDLE, '0, sdsh_pkg::SG_CMD0);
                    end else begin
                        finish_req(sdsh_pkg::ST_NOCARD);
                    end
                end
            end
            sdsh_pkg::SG_CMD8: begin
                if (r1 == tb_sdsh_pkg::R1_IDLE) begin
                    ph = sdsh_pkg::PH_TRAIL;
                    bcnt = 0;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end else begin
                    send_cmd(tb_sdsh_pkg::CMD_APP, '0, sdsh_pkg::SG_PROBE55);
                end
            end
            sdsh_pkg::SG_PROBE55:
                send_cmd(tb_sdsh_pkg::CMD_APP_INIT, '0, sdsh_pkg::SG_PROBE41);
            sdsh_pkg::SG_PROBE41: begin
                rcnt = '0;
                if (r1 <= tb_sdsh_pkg::R1_IDLE) begin
                    kind = sdsh_pkg::CT_V1;
                    send_cmd(tb_sdsh_pkg::CMD_APP, '0, sdsh_pkg::SG_V1_55);
                end else begin
                    kind = sdsh_pkg::CT_MMC;
                    send_cmd(tb_sdsh_pkg::CMD_MMC_INIT, '0, sdsh_pkg::SG_MMC1);
                end
            end
            sdsh_pkg::SG_V1_55:
                send_cmd(tb_sdsh_pkg::CMD_APP_INIT, '0, sdsh_pkg::SG_V1_41);
            sdsh_pkg::SG_V1_41: begin
                if (r1 == tb_sdsh_pkg::R1_READY) begin
                    send_cmd(tb_sdsh_pkg::CMD_BLOCKLEN, sdsh_pkg::BLOCK_BYTES,
                             sdsh_pkg::SG_CMD16);
                end else begin
                    poll_again(tb_sdsh_pkg::CMD_APP, sdsh_pkg::SG_V1_55);
                end
            end
            sdsh_pkg::SG_MMC1: begin
                if (r1 == tb_sdsh_pkg::R1_READY) begin
                    send_cmd(tb_sdsh_pkg::CMD_BLOCKLEN, sdsh_pkg::BLOCK_BYTES,
                             sdsh_pkg::SG_CMD16);
                end else begin
                    poll_again(tb_sdsh_pkg::CMD_MMC_INIT, sdsh_pkg::SG_MMC1);
                end
            end
            sdsh_pkg::SG_V2_55:
                send_cmd(tb_sdsh_pkg::CMD_APP_INIT, tb_sdsh_pkg::HCS_ARG, sdsh_pkg::SG_V2_41);
            sdsh_pkg::SG_V2_41: begin
                if (r1 == tb_sdsh_pkg::R1_READY) begin
                    send_cmd(tb_sdsh_pkg::CMD_READ_OCR, '0, sdsh_pkg::SG_CMD58);
                end else begin
                    poll_again(tb_sdsh_pkg::CMD_APP, sdsh_pkg::SG_V2_55);
                end
            end
            sdsh_pkg::SG_CMD58: begin
                if (r1 == tb_sdsh_pkg::R1_READY) begin
                    ph = sdsh_pkg::PH_TRAIL;
                    bcnt = 0;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end else begin
                    kind = sdsh_pkg::CT_ERROR;
                    finish_req(r1_fail(r1));
                end
            end
            sdsh_pkg::SG_CMD16: begin
                if (r1 == tb_sdsh_pkg::R1_READY) begin
                    finish_req(sdsh_pkg::ST_OK);
                end else begin
                    kind = sdsh_pkg::CT_ERROR;
                    finish_req(r1_fail(r1));
                end
            end
            sdsh_pkg::SG_RDCMD: begin
                if (r1 == tb_sdsh_pkg::R1_READY) enter_wait(sdsh_pkg::PH_TOKEN);
                else finish_req(r1_fail(r1));
            end
            sdsh_pkg::SG_RDSTOP: finish_req(fstat);
            sdsh_pkg::SG_WRCMD: begin
                if (r1 == tb_sdsh_pkg::R1_READY) enter_wait(sdsh_pkg::PH_READY);
                else finish_req(r1_fail(r1));
            end
            default: finish_req(sdsh_pkg::ST_BADRESP);
        endcase
    endtask

    task trail_done();
        if (stg == sdsh_pkg::SG_CMD8) begin
            if (reply[15:8] == tb_sdsh_pkg::VHS_VOLT &&
                reply[7:0] == tb_sdsh_pkg::VHS_PATTERN) begin
                rcnt = '0;
                send_cmd(tb_sdsh_pkg::CMD_APP, '0, sdsh_pkg::SG_V2_55);
            end else begin
                finish_req(sdsh_pkg::ST_NOCARD);
            end
        end else begin
            // card capacity status bit of the OCR
            kind = reply[30] ? sdsh_pkg::CT_V2HC : sdsh_pkg::CT_V2;
            send_cmd(tb_sdsh_pkg::CMD_BLOCKLEN, sdsh_pkg::BLOCK_BYTES, sdsh_pkg::SG_CMD16);
        end
    endtask

    task advance(input logic [7:0] rx, input logic [7:0] wb);
        logic [47:0] sh;
        case (ph)
            sdsh_pkg::PH_WAKE: begin
                if (bcnt < sdsh_pkg::WAKE_BYTES) begin
                    bcnt++;
                    emit(sdsh_pkg::BYTE_FF, 1'b0);
                end else begin
                    send_cmd(tb_sdsh_pkg::CMD_GO_IDLE, '0, sdsh_pkg::SG_CMD0);
                end
            end
            sdsh_pkg::PH_DESEL: begin
                bcnt = 1;
                ph = sdsh_pkg::PH_FRAME;
                emit(frame[47:40], 1'b1);
            end
            sdsh_pkg::PH_FRAME: begin
                if (bcnt < 6) begin
                    sh = frame >> (40 - 8 * bcnt);
                    emit(sh[7:0], 1'b1);
                    bcnt++;
                end else begin
                    // stop command needs one stuff byte before its R1
                    enter_wait((ccmd == tb_sdsh_pkg::CMD_STOP) ? sdsh_pkg::PH_STUFF
                                                               : sdsh_pkg::PH_RESP);
                end
            end
            sdsh_pkg::PH_STUFF: enter_wait(sdsh_pkg::PH_RESP);
            sdsh_pkg::PH_RESP: begin
                if (rx[7] && wcnt < {16'd0, lim_resp}) begin
                    wcnt++;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end else begin
                    on_r1(rx);
                end
            end
            sdsh_pkg::PH_TRAIL: begin
                reply = {reply[23:0], rx};
                bcnt++;
                if (bcnt < 4) emit(sdsh_pkg::BYTE_FF, 1'b1);
                else trail_done();
            end
            sdsh_pkg::PH_TOKEN: begin
                if (rx == sdsh_pkg::TOK_START) begin
                    ph = sdsh_pkg::PH_RDATA;
                    bcnt = 0;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end else begin
                    wcnt++;
                    if (wcnt < {12'd0, lim_token}) emit(sdsh_pkg::BYTE_FF, 1'b1);
                    else block_read(sdsh_pkg::ST_TIMEOUT);
                end
            end
            sdsh_pkg::PH_RDATA: begin
                res.read_data = rx;
                res.read_valid = 1'b1;
                bcnt++;
                if (bcnt >= sdsh_pkg::BLOCK_BYTES) begin
                    ph = sdsh_pkg::PH_RCRC;
                    bcnt = 0;
                end
                emit(sdsh_pkg::BYTE_FF, 1'b1);
            end
            sdsh_pkg::PH_RCRC: begin
                if (bcnt == 0) begin
                    bcnt = 1;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end else begin
                    block_read(sdsh_pkg::ST_OK);
                end
            end
            sdsh_pkg::PH_READY: begin
                if (rx == sdsh_pkg::BYTE_FF) begin
                    ph = sdsh_pkg::PH_WTOKEN;
                    emit(stopping ? sdsh_pkg::TOK_STOP
                         : (multi ? sdsh_pkg::TOK_MULTI : sdsh_pkg::TOK_START), 1'b1);
                    res.data_request = !stopping;
                end else begin
                    wcnt++;
                    if (wcnt < lim_ready) emit(sdsh_pkg::BYTE_FF, 1'b1);
                    else block_written(sdsh_pkg::ST_TIMEOUT);
                end
            end
            sdsh_pkg::PH_WTOKEN: begin
                if (stopping) begin
                    finish_req(fstat);
                end else begin
                    ph = sdsh_pkg::PH_WDATA;
                    bcnt = 1;
                    emit(wb, 1'b1);
                    res.data_request = (bcnt < sdsh_pkg::BLOCK_BYTES);
                end
            end
            sdsh_pkg::PH_WDATA: begin
                if (bcnt < sdsh_pkg::BLOCK_BYTES) begin
                    emit(wb, 1'b1);
                    bcnt++;
                    res.data_request = (bcnt < sdsh_pkg::BLOCK_BYTES);
                end else begin
                    ph = sdsh_pkg::PH_WCRC;
                    bcnt = 0;
                    emit(sdsh_pkg::BYTE_FF, 1'b1);
                end
            end
            sdsh_pkg::PH_WCRC: begin
                if (bcnt == 0) bcnt = 1;
                else ph = sdsh_pkg::PH_WRESP;
                emit(sdsh_pkg::BYTE_FF, 1'b1);
            end
            sdsh_pkg::PH_WRESP:
                block_written((rx[4:0] == tb_sdsh_pkg::DRESP_OK) ? sdsh_pkg::ST_OK
                                                                 : sdsh_pkg::ST_BADRESP);
            sdsh_pkg::PH_END: begin
                res.done_res = 1'b1;
                res.status = fstat;
                ph = sdsh_pkg::PH_IDLE;
                req = sdsh_pkg::RQ_NONE;
            end
            default: ph = sdsh_pkg::PH_IDLE;
        endcase
    endtask

    task start_req(input logic [1:0] cmd, input logic [31:0] sector,
                   input logic [7:0] count);
        logic [31:0] addr;
        req = cmd;
        rcnt = '0;
        wcnt = '0;
        bcnt = 0;
        fstat = sdsh_pkg::ST_OK;
        stopping = 1'b0;
        if (cmd == sdsh_pkg::RQ_INIT) begin
            kind = sdsh_pkg::CT_NONE;
            ph = sdsh_pkg::PH_WAKE;
            bcnt = 1;
            emit(sdsh_pkg::BYTE_FF, 1'b0);
            return;
        end
        left = count;
        multi = (count != 8'd1);
        addr = (kind == sdsh_pkg::CT_V2HC) ? sector : (sector << 9);
        if (cmd == sdsh_pkg::RQ_READ) begin
            send_cmd(multi ? tb_sdsh_pkg::CMD_RD_MULTI : tb_sdsh_pkg::CMD_RD_SINGLE, addr,
                     sdsh_pkg::SG_RDCMD);
        end else begin
            send_cmd(multi ? tb_sdsh_pkg::CMD_WR_MULTI : tb_sdsh_pkg::CMD_WR_SINGLE, addr,
                     sdsh_pkg::SG_WRCMD);
        end
    endtask

    task sd_host_step(input logic [63:0] item);
        res = '0;
        if (item[1:0] != sdsh_pkg::RQ_NONE) start_req(item[1:0], item[41:10], item[49:42]);
        else if (ph != sdsh_pkg::PH_IDLE) advance(item[9:2], item[57:50]);
        res.slow_clock = res.send_valid && (req == sdsh_pkg::RQ_INIT);
        res.card_type = kind;
    endtask

    task cmp_field(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            n_errors++;
        end
    endtask

    initial begin
        n_errors = 0;
        n_pending = 0;
        host_reset();
    end

    always @(posedge aclk) begin
        sdsh_pkg::result_t got, want;
        if (!aresetn) begin
            host_reset();
            due_answers.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    sdsh_pkg::RG_READY: lim_ready = pwdata[23:0];
                    sdsh_pkg::RG_TOKEN: lim_token = pwdata[11:0];
                    sdsh_pkg::RG_RESP:  lim_resp  = pwdata[7:0];
                    sdsh_pkg::RG_IDLE:  lim_idle  = pwdata[7:0];
                    sdsh_pkg::RG_POLL:  lim_poll  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = sdsh_pkg::result_t'(m_axis_tdata[26:0]);
                if (due_answers.size() == 0) begin
                    $error("result transfer with no request outstanding: 0x%0h",
                           m_axis_tdata);
                    n_errors++;
                end else begin
                    want = due_answers.pop_front();
                    cmp_field("tx_byte", want.tx_byte, got.tx_byte);
                    cmp_field("send_valid", want.send_valid, got.send_valid);
                    cmp_field("chip_select", want.chip_select, got.chip_select);
                    cmp_field("slow_clock", want.slow_clock, got.slow_clock);
                    cmp_field("read_data", want.read_data, got.read_data);
                    cmp_field("read_valid", want.read_valid, got.read_valid);
                    cmp_field("data_request", want.data_request, got.data_request);
                    cmp_field("done_res", want.done_res, got.done_res);
                    cmp_field("status", want.status, got.status);
                    cmp_field("card_type", want.card_type, got.card_type);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sd_host_step(s_axis_tdata);
                due_answers.push_back(res);
            end
        end
        n_pending = due_answers.size();
    end

endmodule

// ----- test/tb_sd_card_spi_host_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_card_spi_host_engine
// Drives the SD SPI host engine with host requests and emulated card replies
// under random flow control and register settings; the checker scores it.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_engine;

    typedef enum int {P_V2HC, P_V2, P_V1, P_MMC, P_NOCARD} card_prof_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int n_errors, n_pending;

    sd_card_spi_host_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sdsh_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .n_errors(n_errors), .n_pending(n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: stretches of always-ready, light stalls and heavy stalls
    int sink_mode = 0;
    int sink_left = 0;
    always @(posedge aclk) begin
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 2);
            sink_left <= $urandom_range(5, 60);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // card emulation and bookkeeping
    card_prof_t  prof = P_V2HC;
    int          fcnt, post_n, dly, wr_cnt;
    logic        prev_dr;
    logic [5:0]  card_cmd;
    logic [7:0]  lim_resp = 8'd31;
    logic [7:0]  lim_idle = 8'd20;
    int          burst_left = 0;
    int          n_items = 0;
    int          n_init = 0, n_read = 0, n_write = 0, n_done = 0, n_abort = 0;
    int          n_rdbytes = 0, n_wrbytes = 0;
    logic        ended_clean;

    function automatic logic [7:0] noisy(input logic [7:0] v);
        return ($urandom_range(0, 19) == 0) ? 8'($urandom) : v;
    endfunction

    function logic [7:0] r1_reply(input logic [5:0] cmd);
        logic [7:0] v;
        case (cmd)
            tb_sdsh_pkg::CMD_GO_IDLE: begin
                if (prof == P_NOCARD && (lim_idle <= 8'd24 || $urandom_range(0, 3) != 0)) begin
                    v = 8'($urandom);
                    if (v == tb_sdsh_pkg::R1_IDLE) v = sdsh_pkg::BYTE_FF;
                end else begin
                    v = tb_sdsh_pkg::R1_IDLE;
                end
            end
            tb_sdsh_pkg::CMD_IF_COND:
                v = (prof == P_V2 || prof == P_V2HC) ? tb_sdsh_pkg::R1_IDLE
                                                      : tb_sdsh_pkg::R1_ILLEGAL;
            tb_sdsh_pkg::CMD_APP: v = tb_sdsh_pkg::R1_IDLE;
            tb_sdsh_pkg::CMD_APP_INIT:
                v = (prof == P_MMC) ? tb_sdsh_pkg::R1_ILLEGAL :
                    (($urandom_range(0, 2) == 0) ? tb_sdsh_pkg::R1_READY
                                                 : tb_sdsh_pkg::R1_IDLE);
            tb_sdsh_pkg::CMD_MMC_INIT:
                v = ($urandom_range(0, 2) == 0) ? tb_sdsh_pkg::R1_READY
                                                : tb_sdsh_pkg::R1_IDLE;
            default: v = tb_sdsh_pkg::R1_READY;
        endcase
        return noisy(v);
    endfunction

    // byte the card returns during the transfer that carried result r
    function logic [7:0] card_byte(input sdsh_pkg::result_t r);
        int k;
        logic [7:0] v;
        if (prev_dr && !r.data_request) wr_cnt = 1;
        else if (wr_cnt > 0) wr_cnt++;
        prev_dr = r.data_request;
        if (!r.chip_select) begin
            fcnt = 0;
            return ($urandom_range(0, 3) == 0) ? 8'($urandom) : sdsh_pkg::BYTE_FF;
        end
        if (fcnt < 6) begin
            if (fcnt == 0) begin
                card_cmd = r.tx_byte[5:0];
                post_n = 0;
                dly = $urandom_range(0, (lim_resp < 8'd2) ? lim_resp : 2);
            end
            fcnt++;
            return sdsh_pkg::BYTE_FF;
        end
        // data response lands on the third filler after the last data byte
        if (wr_cnt == 4) begin
            wr_cnt = 0;
            return ($urandom_range(0, 7) != 0)
                ? {3'($urandom), 1'b0, tb_sdsh_pkg::DRESP_OK[3:0]} : 8'($urandom);
        end
        k = post_n - dly - 1;
        post_n++;
        if (k < -1) return sdsh_pkg::BYTE_FF;
        if (k == -1) return r1_reply(card_cmd);
        case (card_cmd)
            tb_sdsh_pkg::CMD_IF_COND: begin
                case (k)
                    0, 1: v = 8'h00;
                    2: v = tb_sdsh_pkg::VHS_VOLT;
                    3: v = tb_sdsh_pkg::VHS_PATTERN;
                    default: v = sdsh_pkg::BYTE_FF;
                endcase
                return noisy(v);
            end
            tb_sdsh_pkg::CMD_READ_OCR: begin
                v = 8'($urandom);
                if (k == 0) v = {1'b1, prof == P_V2HC, v[5:0]};
                return noisy(v);
            end
            tb_sdsh_pkg::CMD_RD_SINGLE, tb_sdsh_pkg::CMD_RD_MULTI:
                return ($urandom_range(0, 3) == 0) ? sdsh_pkg::TOK_START : 8'($urandom);
            tb_sdsh_pkg::CMD_WR_SINGLE, tb_sdsh_pkg::CMD_WR_MULTI:
                return ($urandom_range(0, 6) != 0) ? sdsh_pkg::BYTE_FF : 8'($urandom);
            default: return sdsh_pkg::BYTE_FF;
        endcase
    endfunction

    task push_item(input logic [1:0] cmd, input logic [7:0] rx, input logic [31:0] sector,
                   input logic [7:0] count, output sdsh_pkg::result_t r);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata <= {6'd0, 8'($urandom), count, sector, rx, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        s_axis_tvalid <= 1'b0;
        n_items++;
        @(posedge aclk);
        while (!(m_axis_tvalid && m_axis_tready)) @(posedge aclk);
        r = sdsh_pkg::result_t'(m_axis_tdata[26:0]);
    endtask

    task run_request(input logic [1:0] op, input logic [31:0] sector, input logic [7:0] count,
                     input int abort_at);
        sdsh_pkg::result_t r;
        int n;
        fcnt = 0; wr_cnt = 0; prev_dr = 1'b0; n = 0;
        ended_clean = 1'b0;
        case (op)
            sdsh_pkg::RQ_INIT:  n_init++;
            sdsh_pkg::RQ_READ:  n_read++;
            sdsh_pkg::RQ_WRITE: n_write++;
            default: ;
        endcase
        push_item(op, 8'($urandom), sector, count, r);
        while (r.send_valid) begin
            if ((abort_at > 0 && n >= abort_at) || $urandom_range(0, 999) == 0) begin
                n_abort++;
                return;
            end
            if (r.data_request) n_wrbytes++;
            push_item(sdsh_pkg::RQ_NONE, card_byte(r), $urandom, 8'($urandom), r);
            if (r.read_valid) n_rdbytes++;
            n++;
        end
        if (r.done_res) n_done++;
        ended_clean = 1'b1;
    endtask

    task init_card(input card_prof_t p);
        prof = p;
        run_request(sdsh_pkg::RQ_INIT, $urandom, 8'($urandom), 0);
    endtask

    task reg_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == sdsh_pkg::RG_RESP) lim_resp = v[7:0];
        if (idx == sdsh_pkg::RG_IDLE) lim_idle = v[7:0];
    endtask

    function automatic logic [31:0] pick(input int style, input logic [31:0] hi);
        case (style)
            0: return hi;
            1: return 32'd1;
            default: begin
                case ($urandom_range(0, 5))
                    0: return hi;
                    1: return 32'd1;
                    2: return 32'd0;
                    default: return $urandom_range(1, (hi > 32'd300) ? 300 : hi);
                endcase
            end
        endcase
    endfunction

    // only called with the engine idle; the upper bits of pwdata carry junk
    task set_limits(input int style);
        logic [31:0] v;
        while (n_pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        v = pick(style, 32'hFF_FFFF);
        reg_write(sdsh_pkg::RG_READY, {8'($urandom), v[23:0]});
        v = pick(style, 32'hFFF);
        reg_write(sdsh_pkg::RG_TOKEN, {20'($urandom), v[11:0]});
        v = pick(style, 32'hFF);
        reg_write(sdsh_pkg::RG_RESP,  {24'($urandom), v[7:0]});
        v = pick(style, 32'hFF);
        reg_write(sdsh_pkg::RG_IDLE,  {24'($urandom), v[7:0]});
        v = pick(style, 32'hFFFF);
        reg_write(sdsh_pkg::RG_POLL,  {16'($urandom), v[15:0]});
    endtask

    initial begin
        int since_cfg;
        int roll;
        logic [7:0] cnt;
        logic [31:0] sec;
        since_cfg = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle report, request before init, every card flavor
        run_request(sdsh_pkg::RQ_NONE, '1, 8'hFF, 0);
        run_request(sdsh_pkg::RQ_READ, '1, 8'd1, 40);
        init_card(P_NOCARD);
        init_card(P_MMC);
        run_request(sdsh_pkg::RQ_WRITE, '0, 8'd1, 0);
        init_card(P_V1);
        init_card(P_V2);
        init_card(P_V2HC);
        // zero count means 256 sectors; cut short by a new request
        run_request(sdsh_pkg::RQ_WRITE, 32'h8000_0000, 8'd0, 60);

        init_card(P_V2HC);
        set_limits(0);
        for (int ph = 0; n_items < 1400; ph++) begin
            if (ended_clean && since_cfg >= 5) begin
                set_limits(ph < 20 ? 1 : 2);
                since_cfg = 0;
            end
            since_cfg++;
            roll = $urandom_range(0, 99);
            sec = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
            cnt = ($urandom_range(0, 9) < 8) ? 8'd1 : 8'd2;
            if (roll < 18) begin
                init_card(card_prof_t'($urandom_range(0, 4)));
            end else if (roll < 22) begin
                run_request(sdsh_pkg::RQ_NONE, sec, cnt, 0);
            end else if (roll < 27) begin
                run_request($urandom_range(0, 1) ? sdsh_pkg::RQ_READ : sdsh_pkg::RQ_WRITE,
                            sec, 8'($urandom), $urandom_range(20, 600));
            end else begin
                run_request(roll < 63 ? sdsh_pkg::RQ_READ : sdsh_pkg::RQ_WRITE, sec, cnt, 0);
            end
        end

        while (n_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("%0d items: %0d init, %0d read, %0d write requests, %0d completed, %0d cut",
                 n_items, n_init, n_read, n_write, n_done, n_abort);
        $display("sector bytes moved: %0d read, %0d written", n_rdbytes, n_wrbytes);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sd_card_spi_host_engine.f -----
design/sdsh_pkg.sv
design/sd_card_spi_host_engine.sv
test/tb_sdsh_pkg.sv
test/sdsh_checker.sv
test/tb_sd_card_spi_host_engine.sv
